// ===== design/crs_pkg.sv =====
// Shared types, constants and a helper function for the coordinate record sorter.
package crs_pkg;

	// Storage and field sizes
	localparam int MAX_RECORDS = 64;
	localparam int MAX_DIMS    = 3;
	localparam int COORD_W     = 32;
	localparam int IDX_W       = $clog2(MAX_RECORDS);
	localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
	localparam int LANE_W      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int KEY_W       = 2 * COORD_W + IDX_W;

	// Configuration port
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 2;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIMS = 1'd1;

	// One incoming record
	typedef struct packed {
		logic [COORD_W-1:0] coord_a;
		logic [COORD_W-1:0] coord_b;
		logic [COORD_W-1:0] coord_c;
		logic [COORD_W-1:0] payload;
		logic               in_last;
	} in_req_t;

	// One emitted record
	typedef struct packed {
		logic [COORD_W-1:0] out_coord_a;
		logic [COORD_W-1:0] out_coord_b;
		logic [COORD_W-1:0] out_coord_c;
		logic [COORD_W-1:0] out_payload;
		logic               out_last;
		logic               overflow;
	} out_rec_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_FETCH,
		ST_CAPTURE,
		ST_SEND
	} state_t;

	// Index position pos reduced modulo the effective dimension count.
	// Both operands are tiny, so a few conditional subtractions do the job.
	function automatic logic [LANE_W-1:0] key_lane(input logic [2:0] pos,
			input logic [1:0] dims);
		logic [2:0] d;
		logic [2:0] r;
		if (dims == 2'd0) begin
			d = 3'd1;
		end else if (32'(dims) > MAX_DIMS) begin
			d = 3'(MAX_DIMS);
		end else begin
			d = {1'b0, dims};
		end
		r = pos;
		for (int i = 0; i < 4; i++) begin
			if (r >= d) begin
				r = r - d;
			end
		end
		return LANE_W'(r);
	endfunction

endpackage

// ===== design/crs_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module crs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/coordinate_record_sorter.sv =====
// Coordinate record sorter: collects a set of records and emits them in stable key order.
//
// Records are taken one per cycle while the block is loading, up to 64 of them; any
// further record of the set is dropped and every result of that set carries the overflow
// flag. The request marked last is stored too while there is room and starts the output
// phase, during which the block takes no request. Each result is found by one pass over
// all n stored records through the single read port of the record store, comparing each
// against the best candidate so far on the key (primary index, secondary index, arrival
// position); the winner is then read back and offered until the output side takes it.
// Primary and secondary index positions come from the axis and dimension registers as
// they stand when the last request is accepted.
module coordinate_record_sorter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [crs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crs_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  crs_pkg::in_req_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output crs_pkg::out_rec_t              out_data
);
	import crs_pkg::*;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic               dropped_q;
	logic [1:0]         axis_q;
	logic [1:0]         dims_q;
	logic [LANE_W-1:0]  k1_q, k2_q;
	logic [IDX_W-1:0]   scan_q;
	logic [IDX_W-1:0]   emit_q;
	logic               valid_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               best_valid_q;
	logic [KEY_W-1:0]   best_key_q;
	logic [KEY_W-1:0]   prev_key_q;
	out_rec_t           out_q;

	logic               in_acc;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [IDX_W-1:0]   rd_addr;
	logic               scan_last;
	logic               emit_last;
	logic               send_done;
	logic [KEY_W-1:0]   cand_key;
	logic               take;
	logic [COORD_W-1:0] in_coord  [3];
	logic [COORD_W-1:0] rd_coord  [MAX_DIMS];
	logic [COORD_W-1:0] out_coord [3];
	logic [COORD_W-1:0] rd_payload;

	assign in_coord[0] = in_data.coord_a;
	assign in_coord[1] = in_data.coord_b;
	assign in_coord[2] = in_data.coord_c;

	// Store a request while there is room
	assign in_acc  = in_valid && in_ready;
	assign wr_en   = in_acc && (count_q < CNT_W'(MAX_RECORDS));
	assign wr_addr = count_q[IDX_W-1:0];

	// Record store: one lane per stored index position, plus the payload word
	for (genvar p = 0; p < MAX_DIMS; p++) begin : g_lane
		crs_ram #(
			.WIDTH(COORD_W),
			.DEPTH(MAX_RECORDS)
		) u_coord_ram (
			.clk  (clk),
			.we   (wr_en),
			.waddr(wr_addr),
			.wdata(in_coord[p]),
			.raddr(rd_addr),
			.rdata(rd_coord[p])
		);
	end

	crs_ram #(
		.WIDTH(COORD_W),
		.DEPTH(MAX_RECORDS)
	) u_payload_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(in_data.payload),
		.raddr(rd_addr),
		.rdata(rd_payload)
	);

	// Index positions that are not stored are emitted as zero
	for (genvar p = 0; p < 3; p++) begin : g_out
		if (p < MAX_DIMS) begin : g_stored
			assign out_coord[p] = rd_coord[p];
		end else begin : g_zero
			assign out_coord[p] = '0;
		end
	end

	assign scan_last = (CNT_W'(scan_q) == count_q - CNT_W'(1));
	assign emit_last = (CNT_W'(emit_q) == count_q - CNT_W'(1));
	assign send_done = (state_q == ST_SEND) && out_ready;

	// Shared compare unit: the candidate must follow the last emitted record, if any, and
	// precede the best one found so far in this pass.
	assign cand_key = {rd_coord[k1_q], rd_coord[k2_q], idx_s1};
	assign take     = valid_s1
		&& ((emit_q == '0) || (cand_key > prev_key_q))
		&& (!best_valid_q || (cand_key < best_key_q));

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, handshake and read address
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		rd_addr   = scan_q;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid && in_data.in_last) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_addr = scan_q;
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FETCH;
			end
			ST_FETCH: begin
				rd_addr = best_key_q[IDX_W-1:0];
				state_d = ST_CAPTURE;
			end
			ST_CAPTURE: begin
				rd_addr = best_key_q[IDX_W-1:0];
				state_d = ST_SEND;
			end
			ST_SEND: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = emit_last ? ST_LOAD : ST_SCAN;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// Control registers: configuration, fill count, pass counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q       <= 2'd0;
			dims_q       <= 2'd2;
			count_q      <= '0;
			dropped_q    <= 1'b0;
			k1_q         <= '0;
			k2_q         <= '0;
			scan_q       <= '0;
			emit_q       <= '0;
			valid_s1     <= 1'b0;
			best_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_AXIS: axis_q <= cfg_data[1:0];
					REG_DIMS: dims_q <= cfg_data[1:0];
					default: ;
				endcase
			end

			valid_s1 <= (state_q == ST_SCAN);

			if (in_acc) begin
				if (wr_en) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					dropped_q <= 1'b1;
				end
				if (in_data.in_last) begin
					k1_q         <= key_lane({1'b0, axis_q}, dims_q);
					k2_q         <= key_lane(3'({1'b0, axis_q}) + 3'd1, dims_q);
					scan_q       <= '0;
					emit_q       <= '0;
					best_valid_q <= 1'b0;
				end
			end

			if (state_q == ST_SCAN) begin
				scan_q <= scan_q + IDX_W'(1);
			end

			if (take) begin
				best_valid_q <= 1'b1;
			end

			// Result taken: start the next pass or close the set
			if (send_done) begin
				if (emit_last) begin
					count_q   <= '0;
					dropped_q <= 1'b0;
				end else begin
					emit_q       <= emit_q + IDX_W'(1);
					scan_q       <= '0;
					best_valid_q <= 1'b0;
				end
			end
		end
	end

	// Data registers: compare stage, best candidate and output record
	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		if (take) begin
			best_key_q <= cand_key;
		end
		if (send_done) begin
			prev_key_q <= best_key_q;
		end
		if (state_q == ST_CAPTURE) begin
			out_q.out_coord_a <= out_coord[0];
			out_q.out_coord_b <= out_coord[1];
			out_q.out_coord_c <= out_coord[2];
			out_q.out_payload <= rd_payload;
			out_q.out_last    <= emit_last;
			out_q.overflow    <= dropped_q;
		end
	end

	assign out_data = out_q;

`ifndef SYNTHESIS
	// Loading and emitting never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("request taken while a result is pending");

	// Every pass over the store finds a next record
	a_pass_finds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |-> best_valid_q)
		else $error("scan pass ended without a candidate");

	// Results are emitted only for stored records
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((count_q != '0) && (CNT_W'(emit_q) < count_q)))
		else $error("result index beyond stored record count");

	// Closing a set empties the store
	a_set_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(send_done && emit_last) |=> ((count_q == '0) && !dropped_q))
		else $error("store not emptied after the last result");
`endif

endmodule

// ===== tb/coordinate_record_sorter_tb.sv =====
// Self-checking testbench for the coordinate record sorter: random sets, stalls, key settings.
module coordinate_record_sorter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crs_pkg::*;

	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_LIMIT  = 3000;
	localparam int PHASE_ITEMS  = 6;
	localparam int RANDOM_PHASES = 16;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_AXIS;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_req_t              in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_rec_t             out_data;

	// Requests waiting to be driven and sorted records waiting to come out
	in_req_t  record_q [$];
	out_rec_t sorted_q [$];

	// Predictor state: the records of the set being loaded and the key registers
	logic [COORD_W-1:0] held_coord [MAX_RECORDS][MAX_DIMS];
	logic [COORD_W-1:0] held_payload [MAX_RECORDS];
	int                 held_count = 0;
	bit                 held_dropped = 1'b0;
	logic [1:0]         key_axis = 2'd0;
	logic [1:0]         key_dims = 2'd2;

	int  queued_items = 0;
	int  accepted_items = 0;
	int  mismatches = 0;
	int  records_seen = 0;
	int  quiet_cycles = 0;
	int  gap_pct = 20;
	int  send_gap = 0;
	int  recv_gap = 0;
	int  hold_left = 0;
	bit  hold_arm = 1'b0;
	bit  hold_done = 1'b0;
	logic next_valid;
	logic next_ready;

	coordinate_record_sorter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t ns, record %0d: %s", $realtime, records_seen, msg);
		mismatches++;
	endtask

	// Key comparison: primary index first, then secondary index.
	function automatic bit precedes(int x, int y, int k1, int k2);
		if (held_coord[x][k1] != held_coord[y][k1]) begin
			return held_coord[x][k1] < held_coord[y][k1];
		end
		return held_coord[x][k2] < held_coord[y][k2];
	endfunction

	// Index positions beyond the stored ones come out as zero.
	function automatic logic [COORD_W-1:0] coord_lane(int rec, int p);
		return (p < MAX_DIMS) ? held_coord[rec][p] : '0;
	endfunction

	// Stores one accepted request; a last request queues the whole set in key order.
	task automatic predict_record(input in_req_t r);
		logic [COORD_W-1:0] lanes [3];
		int       rank [MAX_RECORDS];
		int       d;
		int       k1;
		int       k2;
		int       j;
		out_rec_t rec;
		lanes[0] = r.coord_a;
		lanes[1] = r.coord_b;
		lanes[2] = r.coord_c;
		if (held_count < MAX_RECORDS) begin
			for (int p = 0; p < MAX_DIMS; p++) begin
				held_coord[held_count][p] = lanes[p];
			end
			held_payload[held_count] = r.payload;
			held_count++;
		end else begin
			held_dropped = 1'b1;
		end
		if (!r.in_last) begin
			return;
		end
		d = (key_dims == 2'd0) ? 1 : int'(key_dims);
		if (d > MAX_DIMS) begin
			d = MAX_DIMS;
		end
		k1 = int'(key_axis) % d;
		k2 = (int'(key_axis) + 1) % d;
		// Insertion in arrival order keeps equal keys stable.
		for (int i = 0; i < held_count; i++) begin
			j = i;
			while (j > 0 && precedes(i, rank[j-1], k1, k2)) begin
				rank[j] = rank[j-1];
				j--;
			end
			rank[j] = i;
		end
		for (int i = 0; i < held_count; i++) begin
			rec.out_coord_a = coord_lane(rank[i], 0);
			rec.out_coord_b = coord_lane(rank[i], 1);
			rec.out_coord_c = coord_lane(rank[i], 2);
			rec.out_payload = held_payload[rank[i]];
			rec.out_last    = (i == held_count - 1);
			rec.overflow    = held_dropped;
			sorted_q = {sorted_q, rec};
		end
		held_count = 0;
		held_dropped = 1'b0;
	endtask

	task automatic check_record(input out_rec_t got);
		out_rec_t want;
		if (sorted_q.size() == 0) begin
			report_mismatch($sformatf("record %h with none expected", got));
			return;
		end
		want = sorted_q.pop_front();
		if (got.out_coord_a !== want.out_coord_a)
			report_mismatch($sformatf("out_coord_a %h, expected %h",
				got.out_coord_a, want.out_coord_a));
		if (got.out_coord_b !== want.out_coord_b)
			report_mismatch($sformatf("out_coord_b %h, expected %h",
				got.out_coord_b, want.out_coord_b));
		if (got.out_coord_c !== want.out_coord_c)
			report_mismatch($sformatf("out_coord_c %h, expected %h",
				got.out_coord_c, want.out_coord_c));
		if (got.out_payload !== want.out_payload)
			report_mismatch($sformatf("out_payload %h, expected %h",
				got.out_payload, want.out_payload));
		if (got.out_last !== want.out_last)
			report_mismatch($sformatf("out_last %b, expected %b", got.out_last, want.out_last));
		if (got.overflow !== want.overflow)
			report_mismatch($sformatf("overflow %b, expected %b", got.overflow, want.overflow));
	endtask

	// Request driver: offers queued records, with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_record(in_data);
				accepted_items++;
			end
			if (!in_valid || in_ready) begin
				next_valid = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (record_q.size() > 0) begin
					in_data <= record_q.pop_front();
					next_valid = 1'b1;
					if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
						send_gap = $urandom_range(7, 1);
					end
				end
				in_valid <= next_valid;
			end
		end
	end

	// Result monitor: checks each sorted record and stalls the output side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			quiet_cycles = 0;
			recv_gap = 0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				check_record(out_data);
				records_seen++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (hold_arm && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			next_ready = 1'b1;
			if (hold_left > 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				next_ready = 1'b0;
			end else if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
				recv_gap = $urandom_range(6, 0);
				next_ready = 1'b0;
			end
			out_ready <= next_ready;
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	initial begin
		@(posedge arst_n);
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
		end
		$display("== FAIL ==");
		$finish;
	end

	task automatic push_record(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b,
			input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] p, input logic last);
		in_req_t r;
		r.coord_a = a;
		r.coord_b = b;
		r.coord_c = c;
		r.payload = p;
		r.in_last = last;
		record_q = {record_q, r};
		queued_items++;
	endtask

	// Small indices in four of ten picks so that keys tie often, plus corners and full-range values.
	function automatic logic [COORD_W-1:0] pick_index();
		case ($urandom_range(9))
			0, 1, 2, 3: return COORD_W'($urandom_range(3));
			4: begin
				case ($urandom_range(3))
					0: return '0;
					1: return '1;
					2: return {1'b1, {(COORD_W-1){1'b0}}};
					default: return {1'b0, {(COORD_W-1){1'b1}}};
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic add_set(input int n);
		for (int i = 0; i < n; i++) begin
			push_record(pick_index(), pick_index(), pick_index(), $urandom, i == n - 1);
		end
	endtask

	// Waits until every request is taken and every sorted record has come out.
	task automatic settle();
		@(posedge clk);
		while (accepted_items != queued_items || sorted_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_AXIS) begin
			key_axis = val;
		end else begin
			key_dims = val;
		end
	endtask

	// Stimulus sequence
	initial begin
		int phase_items;
		int n;
		int roll;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Single-record sets at both extremes of every field.
		push_record('0, '0, '0, '0, 1'b1);
		push_record('1, '1, '1, '1, 1'b1);
		// Ties on the primary and secondary key must keep arrival order.
		push_record(32'd5, 32'd1, 32'd9, 32'hA, 1'b0);
		push_record(32'd5, 32'd1, 32'd7, 32'hB, 1'b0);
		push_record(32'd2, 32'd9, 32'd0, 32'hC, 1'b0);
		push_record(32'd5, 32'd0, 32'd1, 32'hD, 1'b0);
		push_record('1, 32'd0, 32'd0, 32'hE, 1'b0);
		push_record(32'd2, 32'd9, 32'd3, 32'hF, 1'b1);
		// The key setting in force when the last record arrives decides the order.
		push_record(32'd3, 32'd1, 32'd0, 32'h10, 1'b0);
		push_record(32'd1, 32'd2, 32'd0, 32'h11, 1'b0);
		push_record(32'd2, 32'd0, 32'd0, 32'h12, 1'b0);
		settle();
		write_reg(REG_AXIS, 2'd1);
		push_record(32'd0, 32'd3, 32'd0, 32'h13, 1'b0);
		push_record(32'd4, 32'd2, 32'd0, 32'h14, 1'b1);
		// A dimension count of zero acts as one, with the axis reduced to zero.
		settle();
		write_reg(REG_DIMS, 2'd0);
		write_reg(REG_AXIS, 2'd3);
		push_record(32'd7, 32'd1, 32'd5, 32'h20, 1'b0);
		push_record(32'd7, 32'd0, 32'd4, 32'h21, 1'b0);
		push_record(32'd2, 32'd5, 32'd3, 32'h22, 1'b0);
		push_record(32'd7, 32'd1, 32'd2, 32'h23, 1'b1);
		// Axis three wraps around over three dimensions.
		settle();
		write_reg(REG_DIMS, 2'd3);
		push_record(32'd1, 32'd2, 32'd3, 32'h30, 1'b0);
		push_record(32'd1, 32'd2, 32'd1, 32'h31, 1'b0);
		push_record(32'd0, 32'd9, 32'd9, 32'h32, 1'b1);

		// A full store, a dropped last record, a long overflow, then a clean set.
		settle();
		write_reg(REG_AXIS, 2'd2);
		add_set(MAX_RECORDS);
		add_set(MAX_RECORDS + 1);
		add_set(MAX_RECORDS + 6);
		add_set(3);

		// Random sets over every combination of axis and dimension count.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			write_reg(REG_AXIS, CFG_W'(ph % 4));
			write_reg(REG_DIMS, CFG_W'((ph / 4 + ph) % 4));
			if (ph == 5 || ph >= RANDOM_PHASES - 2) begin
				gap_pct = 0;
			end else begin
				gap_pct = 10 * $urandom_range(4, 1);
			end
			if (ph == 3) begin
				hold_arm = 1'b1;
			end
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				roll = $urandom_range(99);
				if (roll < 80) begin
					n = $urandom_range(8, 1);
				end else if (roll < 95) begin
					n = $urandom_range(24, 9);
				end else begin
					n = $urandom_range(40, 25);
				end
				add_set(n);
				phase_items += n;
			end
		end

		settle();
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
